// ===== rtl/chmc_pkg.sv =====
// Package for the compass heading calibration unit: beat types, commands, CORDIC constants.
package chmc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SAMPLE_BITS  = 16;

  localparam int ATAN_DEPTH = 24;
  localparam int STEP_W     = $clog2(ATAN_DEPTH);
  localparam int DIFF_W     = 18;
  localparam int PROD_W     = DIFF_W + 16;
  localparam int PRESCALE_SH = 24;
  localparam int CORDIC_W   = PROD_W + PRESCALE_SH + 2;
  localparam int Z_W        = 34;

  localparam logic signed [15:0] EXT_LOW  = -16'sd10000;
  localparam logic signed [15:0] EXT_HIGH = 16'sd10000;

  localparam logic signed [Z_W-1:0] ANGLE_PI   = Z_W'(64'd2147483648);
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'd32768);

  localparam logic [29:0] ATAN_TAB [ATAN_DEPTH] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef struct packed {
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic               heading_valid;
    logic signed [15:0] x_center;
    logic signed [15:0] y_center;
    logic [14:0]        x_half_span;
    logic [14:0]        y_half_span;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_DIFF,
    S_MUL,
    S_INIT,
    S_ITER,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              span;
    logic              diff;
    logic              mul;
    logic              init;
    logic              iter;
    logic              finish;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic result_busy;
  } ctrl_status_t;

endpackage

// ===== rtl/chmc_ctrl.sv =====
// Sequencer for extreme update, span/center, products and CORDIC iterations.
module chmc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  chmc_pkg::ctrl_status_t status,
  output chmc_pkg::ctrl_cmd_t    cmd
);

  chmc_pkg::state_t state, state_next;
  logic [chmc_pkg::STEP_W-1:0] step, step_next;
  logic last_step;

  assign last_step = (step == chmc_pkg::STEP_W'(chmc_pkg::CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chmc_pkg::S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      chmc_pkg::S_IDLE: begin
        if (sample_valid) state_next = chmc_pkg::S_SPAN;
      end
      chmc_pkg::S_SPAN: state_next = chmc_pkg::S_DIFF;
      chmc_pkg::S_DIFF: state_next = chmc_pkg::S_MUL;
      chmc_pkg::S_MUL:  state_next = chmc_pkg::S_INIT;
      chmc_pkg::S_INIT: begin
        state_next = chmc_pkg::S_ITER;
        step_next  = '0;
      end
      chmc_pkg::S_ITER: begin
        if (last_step) begin
          state_next = chmc_pkg::S_DONE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      chmc_pkg::S_DONE: begin
        if (!status.result_busy) state_next = chmc_pkg::S_IDLE;
      end
      default: state_next = chmc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    cmd          = '0;
    cmd.step     = step;
    case (state)
      chmc_pkg::S_IDLE: begin
        sample_ready = 1'b1;
        cmd.load     = sample_valid;
      end
      chmc_pkg::S_SPAN: cmd.span = 1'b1;
      chmc_pkg::S_DIFF: cmd.diff = 1'b1;
      chmc_pkg::S_MUL:  cmd.mul  = 1'b1;
      chmc_pkg::S_INIT: cmd.init = 1'b1;
      chmc_pkg::S_ITER: cmd.iter = 1'b1;
      chmc_pkg::S_DONE: cmd.finish = !status.result_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/chmc_datapath.sv =====
// Datapath: extremes, spans, centers, cross products, CORDIC vectoring and result register.
module chmc_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  chmc_pkg::sample_t      sample,
  input  chmc_pkg::ctrl_cmd_t    cmd,
  output chmc_pkg::ctrl_status_t status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output chmc_pkg::result_t      result
);

  localparam int CW = chmc_pkg::CORDIC_W;
  localparam int ZW = chmc_pkg::Z_W;
  localparam int PW = chmc_pkg::PROD_W;
  localparam int DW = chmc_pkg::DIFF_W;
  localparam int SB = chmc_pkg::SAMPLE_BITS;

  logic signed [15:0] sx, sy;
  logic signed [15:0] x_smp, y_smp;
  logic signed [15:0] x_hi, x_lo, y_hi, y_lo;
  logic signed [16:0] x_dif, y_dif, x_sum, y_sum, x_sum_adj, y_sum_adj;
  logic [14:0]        x_span, y_span;
  logic signed [15:0] x_ctr, y_ctr;
  logic signed [DW-1:0] dx, ndy;
  logic signed [PW-1:0] op_x, op_y, op_x_next, op_y_next;
  logic signed [CW-1:0] cx_pre, cy_pre, cx, cy, xs, ys;
  logic signed [ZW-1:0] z, z_tab, z_rnd;
  logic                 span_ok, op_zero;

  assign sx = 16'($signed(sample.x_raw[SB-1:0]));
  assign sy = 16'($signed(sample.y_raw[SB-1:0]));

  assign x_dif = {x_hi[15], x_hi} - {x_lo[15], x_lo};
  assign y_dif = {y_hi[15], y_hi} - {y_lo[15], y_lo};
  assign x_sum = {x_hi[15], x_hi} + {x_lo[15], x_lo};
  assign y_sum = {y_hi[15], y_hi} + {y_lo[15], y_lo};
  assign x_sum_adj = x_sum + {16'd0, x_sum[16]};
  assign y_sum_adj = y_sum + {16'd0, y_sum[16]};

  assign op_x_next = dx * $signed({1'b0, y_span});
  assign op_y_next = ndy * $signed({1'b0, x_span});

  assign cx_pre = {{(CW - PW - chmc_pkg::PRESCALE_SH){op_x[PW-1]}}, op_x,
                   {chmc_pkg::PRESCALE_SH{1'b0}}};
  assign cy_pre = {{(CW - PW - chmc_pkg::PRESCALE_SH){op_y[PW-1]}}, op_y,
                   {chmc_pkg::PRESCALE_SH{1'b0}}};

  assign xs    = cx >>> cmd.step;
  assign ys    = cy >>> cmd.step;
  assign z_tab = ZW'(chmc_pkg::ATAN_TAB[cmd.step]);
  assign z_rnd = z + chmc_pkg::ROUND_HALF;

  assign span_ok = (x_span != '0) && (y_span != '0);
  assign op_zero = (op_x == '0) && (op_y == '0);

  assign status.result_busy = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_hi <= chmc_pkg::EXT_LOW;
      x_lo <= chmc_pkg::EXT_HIGH;
      y_hi <= chmc_pkg::EXT_LOW;
      y_lo <= chmc_pkg::EXT_HIGH;
    end else if (cmd.load) begin
      if (sx > x_hi) x_hi <= sx;
      if (sx < x_lo) x_lo <= sx;
      if (sy > y_hi) y_hi <= sy;
      if (sy < y_lo) y_lo <= sy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_smp <= sx;
      y_smp <= sy;
    end
    if (cmd.span) begin
      x_span <= x_dif[15:1];
      y_span <= y_dif[15:1];
      x_ctr  <= x_sum_adj[16:1];
      y_ctr  <= y_sum_adj[16:1];
    end
    if (cmd.diff) begin
      dx  <= DW'(x_smp) - DW'(x_ctr);
      ndy <= DW'(y_ctr) - DW'(y_smp);
    end
    if (cmd.mul) begin
      op_x <= op_x_next;
      op_y <= op_y_next;
    end
    if (cmd.init) begin
      if (op_x < 0) begin
        cx <= -cx_pre;
        cy <= -cy_pre;
        z  <= (op_y >= 0) ? chmc_pkg::ANGLE_PI : -chmc_pkg::ANGLE_PI;
      end else begin
        cx <= cx_pre;
        cy <= cy_pre;
        z  <= '0;
      end
    end
    if (cmd.iter) begin
      if (!cy[CW-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        z  <= z + z_tab;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        z  <= z - z_tab;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.heading       <= (span_ok && !op_zero) ? z_rnd[31:16] : '0;
      result.heading_valid <= span_ok;
      result.x_center      <= x_ctr;
      result.y_center      <= y_ctr;
      result.x_half_span   <= x_span;
      result.y_half_span   <= y_span;
    end
  end

endmodule

// ===== rtl/compass_heading_minmax_calibration_unit.sv =====
// Compass heading unit: min/max hard-iron calibration and CORDIC atan2 heading.
// The sample beat passes through the span/center, difference, product, CORDIC init and iteration states.
// A new sample beat is taken only after the previous one has left the CORDIC loop for the result register.
// The result register holds a finished beat while the next sample is taken.
// Reset (synchronous): extremes to max -10000 / min +10000, sequencer idle, no result.
module compass_heading_minmax_calibration_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  chmc_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output chmc_pkg::result_t result
);

  chmc_pkg::ctrl_cmd_t    cmd;
  chmc_pkg::ctrl_status_t status;

  chmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  chmc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while previous one in flight");

  a_valid_matches_span: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.heading_valid ==
                      ((result.x_half_span != 15'd0) && (result.y_half_span != 15'd0))))
    else $error("heading_valid disagrees with spans");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.heading_valid |-> result.heading == 16'sd0)
    else $error("invalid heading not zero");
`endif

endmodule
